/* src/ise_pkg.sv */
// shared types and constants for the insertion sort engine
package ise_pkg;

  localparam int unsigned KeyWidth = 16;

  typedef logic [KeyWidth-1:0] key_t;

  typedef struct packed {
    key_t key;
    logic final_item;
  } in_item_t;

  typedef struct packed {
    key_t sorted_key;
    logic end_of_run;
    logic overflow;
  } out_item_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctl_t;

endpackage

/* src/ise_stream_if.sv */
// valid/ready stream interface carrying one item per handshake
interface ise_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/ise_cell.sv */
// one cell of the sorting chain: holds a single key and shifts with its neighbors
module ise_cell #(
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                  clk_i,
  input  ise_pkg::cell_ctl_t    ctl_i,
  input  logic                  valid_i,
  input  logic [KEY_BITS-1:0]   ins_key_i,
  input  logic                  prev_gt_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  output logic                  gt_o,
  output logic [KEY_BITS-1:0]   key_o
);

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;

  // an empty cell counts as greater, so the new key lands at the first free slot
  assign gt_o = !valid_i || (key_q > ins_key_i);

  always_comb begin
    key_d = key_q;
    if (ctl_i.insert && gt_o) begin
      key_d = prev_gt_i ? prev_key_i : ins_key_i;
    end else if (ctl_i.drain) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

/* src/insertion_sort_engine_core.sv */
// insertion sort engine: chain of key cells with count, drain control and output register
// throughput: one key accepted per cycle while a set is being collected
// after the final item is accepted, drain_q is set and the output register then takes the first result,
//   then one result per cycle while the sink is ready; each drain step moves one held key out of the chain
// no key is accepted while the chain drains; the next set may start as the last result waits
// reset clears the count, flags and output valid; stored keys stay undefined, no clear pass
module insertion_sort_engine_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ise_stream_if.sink          in_i,
  ise_stream_if.source        out_o
);

  localparam int unsigned StoreBits = (KEY_BITS < ise_pkg::KeyWidth) ? KEY_BITS
                                                                      : ise_pkg::KeyWidth;
  localparam int unsigned CntBits   = $clog2(CAPACITY + 1);

  logic [CntBits-1:0]   count_q;
  logic                 dropped_q;
  logic                 drain_q;
  logic                 run_ovf_q;
  logic                 out_valid_q;
  ise_pkg::out_item_t   out_data_q;

  logic                 accept;
  logic                 full;
  logic                 drain_step;
  logic [StoreBits-1:0] ins_key;
  ise_pkg::cell_ctl_t   ctl;

  logic [StoreBits-1:0] cell_key [CAPACITY];
  logic                 cell_gt  [CAPACITY];
  logic                 cell_vld [CAPACITY];

  assign full       = (count_q == CntBits'(CAPACITY));
  assign in_i.ready = !drain_q;
  assign accept     = in_i.valid && in_i.ready;
  assign drain_step = drain_q && (!out_valid_q || out_o.ready);
  assign ins_key    = in_i.data.key[StoreBits-1:0];

  assign ctl.insert = accept && !full;
  assign ctl.drain  = drain_step;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_gt;
    logic [StoreBits-1:0] prev_key;
    logic [StoreBits-1:0] next_key;

    assign cell_vld[i] = (CntBits'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_key = ins_key;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = cell_key[i];
    end else begin : g_link
      assign next_key = cell_key[i+1];
    end

    ise_cell #(
      .KEY_BITS (StoreBits)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (cell_vld[i]),
      .ins_key_i  (ins_key),
      .prev_gt_i  (prev_gt),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .gt_o       (cell_gt[i]),
      .key_o      (cell_key[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      drain_q     <= 1'b0;
      run_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (!full) begin
          count_q <= count_q + CntBits'(1);
        end
        if (in_i.data.final_item) begin
          // the store is never empty here: either this key went in or it is full
          drain_q   <= 1'b1;
          run_ovf_q <= dropped_q || full;
          dropped_q <= 1'b0;
        end else if (full) begin
          dropped_q <= 1'b1;
        end
      end
      if (drain_step) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q - CntBits'(1);
        if (count_q == CntBits'(1)) begin
          drain_q <= 1'b0;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_step) begin
      out_data_q.sorted_key <= ise_pkg::key_t'(cell_key[0]);
      out_data_q.end_of_run <= (count_q == CntBits'(1));
      out_data_q.overflow   <= run_ovf_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(CAPACITY))
    else $error("held count beyond capacity");

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (count_q != '0))
    else $error("draining an empty chain");

  a_drain_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_step && count_q == CntBits'(1)) |=> (!drain_q && out_o.data.end_of_run))
    else $error("last item of a run not flagged");

  a_head_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_vld[1] |-> (cell_key[0] <= cell_key[1]))
    else $error("chain head out of order");

endmodule
